FILE: sv/tdsm_pkg.sv
// Shared constants, widths, codes and types for the TDS median meter.
// Used by tdsm_front, tdsm_div, tdsm_back and the top level; no dependencies.
package tdsm_pkg;

   // ring geometry
   localparam int SAMPLE_COUNT = 30;
   localparam int IDX_W        = $clog2(SAMPLE_COUNT);
   localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
   localparam logic [CNT_W-1:0] K_LO = CNT_W'((SAMPLE_COUNT - 1) / 2);
   localparam logic [CNT_W-1:0] K_HI = CNT_W'(SAMPLE_COUNT / 2);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);

   // field widths
   localparam int ADC_W  = 10;
   localparam int TEMP_W = 10;
   localparam int MV_W   = 13;
   localparam int PPM_W  = 18;
   localparam int CSR_W  = 13;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_TEMP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MV     = 1'b1;
   localparam logic [TEMP_W-1:0] TEMP_RESET = 10'd400;
   localparam logic [MV_W-1:0]   MV_RESET   = 13'd3300;

   // commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // divider geometry
   localparam int DVD_W     = 30;
   localparam int DVS_W     = 11;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // voltage scaling: median * mV * 64, then divide by 1000 by reciprocal
   localparam int XM_W    = 23;
   localparam int XN_W    = XM_W + 6;
   localparam int XS_W    = 59;
   localparam int X_SHIFT = 39;
   localparam logic [29:0] X_RECIP = 30'd549755814;

   // datapath widths
   localparam int Y_W   = 21;
   localparam int SQ_W  = 2 * Y_W;
   localparam int T1_W  = 56;
   localparam int TY_W  = 36;
   localparam int Q16_W = 41;
   localparam int QLO_W = 21;
   localparam int QHI_W = Q16_W - QLO_W;
   localparam int P_W   = 64;
   localparam int R_W   = P_W - 29;

   // final divide by 100 by reciprocal, valid below the saturation threshold
   localparam int RLO_W   = 25;
   localparam int RQ_W    = 51;
   localparam int R_SHIFT = 32;
   localparam logic [25:0] R_RECIP = 26'd42949673;

   // saturation threshold before the final divide by 100
   localparam logic [R_W-1:0]   R_SAT   = R_W'(26214400);
   localparam logic [PPM_W-1:0] PPM_MAX = '1;

   // status from back end to front end
   typedef struct packed {
      logic pop;
      logic busy;
   } back_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAND,
      ST_SCAN,
      ST_XPROD,
      ST_XSCALE,
      ST_YDIV_GO,
      ST_YDIV_WAIT,
      ST_SQ,
      ST_T1,
      ST_Q16,
      ST_PH,
      ST_PL,
      ST_RCHK,
      ST_OUT
   } back_state_type;

endpackage

FILE: sv/tdsm_front.sv
// Front end: accepts request beats, writes samples into the ring and queues
// query tokens for the back end. Depends on tdsm_pkg.
module tdsm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [tdsm_pkg::ADC_W-1:0]       req_adc_sample,
   input  tdsm_pkg::back_stat_type          stat,
   output logic                             tok_valid,
   input  logic [tdsm_pkg::IDX_W-1:0]       rd_addr,
   output logic [tdsm_pkg::ADC_W-1:0]       rd_data
);

   logic [tdsm_pkg::ADC_W-1:0] ring_ff [tdsm_pkg::SAMPLE_COUNT];
   logic [tdsm_pkg::IDX_W-1:0] wp_ff, wp_in;
   logic [1:0]                 pend_ff, pend_in;
   logic                       accept, push, wr;

   // samples wait while a query is queued or reading the ring
   always_comb begin
      if (req_cmd == tdsm_pkg::CMD_QUERY) begin
         req_ready = (pend_ff != 2'd2);
      end else begin
         req_ready = (pend_ff == 2'd0) && !stat.busy;
      end
   end

   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_cmd == tdsm_pkg::CMD_QUERY);
   assign wr        = accept && (req_cmd == tdsm_pkg::CMD_SAMPLE);
   assign tok_valid = (pend_ff != 2'd0);
   assign rd_data   = ring_ff[rd_addr];

   // token count and write position
   always_comb begin
      pend_in = pend_ff + 2'(push) - 2'(stat.pop);
      wp_in   = wp_ff;
      if (wr) begin
         wp_in = (wp_ff == tdsm_pkg::IDX_LAST) ? '0 : wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         wp_ff   <= '0;
         for (int i = 0; i < tdsm_pkg::SAMPLE_COUNT; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         pend_ff <= pend_in;
         wp_ff   <= wp_in;
         if (wr) begin
            ring_ff[wp_ff] <= req_adc_sample;
         end
      end
   end

endmodule

FILE: sv/tdsm_div.sv
// Restoring divider, one quotient bit per cycle, used for the temperature
// compensation division. Depends on tdsm_pkg.
module tdsm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdsm_pkg::DVD_W-1:0]  dividend,
   input  logic [tdsm_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [tdsm_pkg::DVD_W-1:0]  quotient
);

   logic [tdsm_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [tdsm_pkg::DVD_W-1:0]     quo_ff, quo_in;
   logic [tdsm_pkg::DVS_W-1:0]     dvs_ff;
   logic [tdsm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff, done_ff;
   logic [tdsm_pkg::DVS_W:0]       rem_sh;
   logic                           ge;

   // one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[tdsm_pkg::DVD_W-1]};
      ge     = (rem_sh >= {1'b0, dvs_ff});
      rem_in = ge ? tdsm_pkg::DVS_W'(rem_sh - {1'b0, dvs_ff})
                  : rem_sh[tdsm_pkg::DVS_W-1:0];
      quo_in = {quo_ff[tdsm_pkg::DVD_W-2:0], ge};
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= tdsm_pkg::DIV_CNT_W'(tdsm_pkg::DVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

FILE: sv/tdsm_back.sv
// Back end: rank-selection median over the ring, compensation and
// polynomial, output register and configuration registers.
// Depends on tdsm_pkg and tdsm_div.
module tdsm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             tok_valid,
   output tdsm_pkg::back_stat_type          stat,
   output logic [tdsm_pkg::IDX_W-1:0]       rd_addr,
   input  logic [tdsm_pkg::ADC_W-1:0]       rd_data,
   input  logic                             csr_wr_en,
   input  logic [tdsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsm_pkg::CSR_W-1:0]       csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tdsm_pkg::PPM_W-1:0]       rsp_tds_ppm,
   output logic                             rsp_saturated
);

   tdsm_pkg::back_state_type state_ff, state_in;

   logic [tdsm_pkg::TEMP_W-1:0] temp_ff;
   logic [tdsm_pkg::MV_W-1:0]   mv_ff;

   logic [tdsm_pkg::IDX_W-1:0]  i_ff, j_ff;
   logic [tdsm_pkg::CNT_W-1:0]  lt_ff, le_ff, lt_in, le_in;
   logic [tdsm_pkg::ADC_W-1:0]  cand_ff, lo_ff, hi_ff;
   logic [tdsm_pkg::ADC_W:0]    med_sum;
   logic [tdsm_pkg::ADC_W-1:0]  med;

   logic [tdsm_pkg::XN_W-1:0]   xn_ff;
   logic [tdsm_pkg::XS_W-1:0]   xs_prod;
   logic [tdsm_pkg::Y_W-1:0]    x_ff, y_ff;
   logic [tdsm_pkg::SQ_W-1:0]   sq_ff;
   logic [tdsm_pkg::T1_W-1:0]   t1_ff;
   logic [tdsm_pkg::TY_W-1:0]   ty_ff;
   logic [tdsm_pkg::Q16_W-1:0]  q16_ff;
   logic [tdsm_pkg::Q16_W:0]    ph_ff;
   logic [tdsm_pkg::P_W-1:0]    p_ff;
   logic [tdsm_pkg::R_W-1:0]    r;
   logic                        r_sat;
   logic [tdsm_pkg::RQ_W-1:0]   rq_prod;

   logic                        div_start, div_done;
   logic [tdsm_pkg::DVD_W-1:0]  div_dvd, div_q;
   logic [tdsm_pkg::DVS_W-1:0]  div_dvs;

   logic                        rsp_valid_ff;
   logic [tdsm_pkg::PPM_W-1:0]  ppm_ff;
   logic                        sat_ff;
   logic                        res_sat_ff;
   logic [tdsm_pkg::PPM_W-1:0]  res_ff;
   logic                        out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= tdsm_pkg::TEMP_RESET;
         mv_ff   <= tdsm_pkg::MV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tdsm_pkg::CSR_WATER_TEMP: temp_ff <= csr_wr_data[tdsm_pkg::TEMP_W-1:0];
            tdsm_pkg::CSR_REF_MV:     mv_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // rank counts including the current scan entry
   always_comb begin
      lt_in = lt_ff + tdsm_pkg::CNT_W'(rd_data <  cand_ff);
      le_in = le_ff + tdsm_pkg::CNT_W'(rd_data <= cand_ff);
   end

   assign med_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign med     = med_sum[tdsm_pkg::ADC_W:1];
   assign r       = p_ff[tdsm_pkg::P_W-1:29];
   assign r_sat   = (r >= tdsm_pkg::R_SAT);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // divide by 1000 and by 100 as reciprocal multiplies, exact over the used range
   assign xs_prod = tdsm_pkg::XS_W'(xn_ff) * tdsm_pkg::XS_W'(tdsm_pkg::X_RECIP);
   assign rq_prod = tdsm_pkg::RQ_W'(r[tdsm_pkg::RLO_W-1:0])
                    * tdsm_pkg::RQ_W'(tdsm_pkg::R_RECIP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdsm_pkg::ST_IDLE:      if (tok_valid) state_in = tdsm_pkg::ST_CAND;
         tdsm_pkg::ST_CAND:      state_in = tdsm_pkg::ST_SCAN;
         tdsm_pkg::ST_SCAN: begin
            if (j_ff == tdsm_pkg::IDX_LAST) begin
               state_in = (i_ff == tdsm_pkg::IDX_LAST) ? tdsm_pkg::ST_XPROD
                                                       : tdsm_pkg::ST_CAND;
            end
         end
         tdsm_pkg::ST_XPROD:     state_in = tdsm_pkg::ST_XSCALE;
         tdsm_pkg::ST_XSCALE:    state_in = tdsm_pkg::ST_YDIV_GO;
         tdsm_pkg::ST_YDIV_GO:   state_in = tdsm_pkg::ST_YDIV_WAIT;
         tdsm_pkg::ST_YDIV_WAIT: if (div_done) state_in = tdsm_pkg::ST_SQ;
         tdsm_pkg::ST_SQ:        state_in = tdsm_pkg::ST_T1;
         tdsm_pkg::ST_T1:        state_in = tdsm_pkg::ST_Q16;
         tdsm_pkg::ST_Q16:       state_in = tdsm_pkg::ST_PH;
         tdsm_pkg::ST_PH:        state_in = tdsm_pkg::ST_PL;
         tdsm_pkg::ST_PL:        state_in = tdsm_pkg::ST_RCHK;
         tdsm_pkg::ST_RCHK:      state_in = tdsm_pkg::ST_OUT;
         tdsm_pkg::ST_OUT:       if (out_free) state_in = tdsm_pkg::ST_IDLE;
         default:                state_in = tdsm_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      stat.pop  = 1'b0;
      stat.busy = 1'b0;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      rd_addr   = j_ff;
      unique case (state_ff)
         tdsm_pkg::ST_IDLE: stat.pop = tok_valid;
         tdsm_pkg::ST_CAND: begin
            stat.busy = 1'b1;
            rd_addr   = i_ff;
         end
         tdsm_pkg::ST_SCAN: stat.busy = 1'b1;
         tdsm_pkg::ST_YDIV_GO: begin
            div_start = 1'b1;
            div_dvd   = tdsm_pkg::DVD_W'(x_ff) * tdsm_pkg::DVD_W'(800);
            div_dvs   = tdsm_pkg::DVS_W'(11'd400 + {1'b0, temp_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdsm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tdsm_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // median scan and arithmetic datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tdsm_pkg::ST_IDLE: i_ff <= '0;
         tdsm_pkg::ST_CAND: begin
            cand_ff <= rd_data;
            j_ff    <= '0;
            lt_ff   <= '0;
            le_ff   <= '0;
         end
         tdsm_pkg::ST_SCAN: begin
            lt_ff <= lt_in;
            le_ff <= le_in;
            j_ff  <= j_ff + 1'b1;
            if (j_ff == tdsm_pkg::IDX_LAST) begin
               i_ff <= i_ff + 1'b1;
               if (lt_in <= tdsm_pkg::K_LO && tdsm_pkg::K_LO < le_in) lo_ff <= cand_ff;
               if (lt_in <= tdsm_pkg::K_HI && tdsm_pkg::K_HI < le_in) hi_ff <= cand_ff;
            end
         end
         tdsm_pkg::ST_XPROD: begin
            xn_ff <= {tdsm_pkg::XM_W'(med) * tdsm_pkg::XM_W'(mv_ff), 6'b0};
         end
         tdsm_pkg::ST_XSCALE: x_ff <= tdsm_pkg::Y_W'(xs_prod >> tdsm_pkg::X_SHIFT);
         tdsm_pkg::ST_YDIV_WAIT: if (div_done) y_ff <= div_q[tdsm_pkg::Y_W-1:0];
         tdsm_pkg::ST_SQ:  sq_ff <= tdsm_pkg::SQ_W'(y_ff) * tdsm_pkg::SQ_W'(y_ff);
         tdsm_pkg::ST_T1: begin
            t1_ff <= tdsm_pkg::T1_W'(sq_ff) * tdsm_pkg::T1_W'(13342);
            ty_ff <= tdsm_pkg::TY_W'(y_ff) * tdsm_pkg::TY_W'(25586);
         end
         tdsm_pkg::ST_Q16: begin
            q16_ff <= tdsm_pkg::Q16_W'(t1_ff[tdsm_pkg::T1_W-1:16])
                      + (tdsm_pkg::Q16_W'(85739) << 16)
                      - tdsm_pkg::Q16_W'(ty_ff);
         end
         tdsm_pkg::ST_PH: begin
            ph_ff <= {1'b0, tdsm_pkg::Q16_W'(q16_ff[tdsm_pkg::Q16_W-1:tdsm_pkg::QLO_W])
                            * tdsm_pkg::Q16_W'(y_ff)};
         end
         tdsm_pkg::ST_PL: begin
            p_ff <= (tdsm_pkg::P_W'(ph_ff) << tdsm_pkg::QLO_W)
                    + tdsm_pkg::P_W'(tdsm_pkg::SQ_W'(q16_ff[tdsm_pkg::QLO_W-1:0])
                                     * tdsm_pkg::SQ_W'(y_ff));
         end
         tdsm_pkg::ST_RCHK: begin
            res_sat_ff <= r_sat;
            res_ff     <= r_sat ? tdsm_pkg::PPM_MAX
                                : tdsm_pkg::PPM_W'(rq_prod >> tdsm_pkg::R_SHIFT);
         end
         tdsm_pkg::ST_OUT: begin
            if (out_free) begin
               ppm_ff <= res_ff;
               sat_ff <= res_sat_ff;
            end
         end
         default: ;
      endcase
   end

   tdsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tds_ppm   = ppm_ff;
   assign rsp_saturated = sat_ff;

endmodule

FILE: sv/tds_median_compensated_meter.sv
// TDS meter top level: median filter, temperature compensation, cubic map.
// Depends on tdsm_pkg, tdsm_front and tdsm_back.
// A sample beat is written into the ring when accepted; a query gives rsp_valid after
// the rank-selection median over the ring, voltage scaling, the serial compensation
// division, and the multiply and clip steps.
// The back end takes one query at a time; two queries queue in front.
// Reset: synchronous, clears ring, write position, queue and output valid.
module tds_median_compensated_meter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [tdsm_pkg::ADC_W-1:0]       req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tdsm_pkg::PPM_W-1:0]       rsp_tds_ppm,
   output logic                             rsp_saturated,
   input  logic                             csr_wr_en,
   input  logic [tdsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsm_pkg::CSR_W-1:0]       csr_wr_data
);

   tdsm_pkg::back_stat_type     stat;
   logic                        tok_valid;
   logic [tdsm_pkg::IDX_W-1:0]  rd_addr;
   logic [tdsm_pkg::ADC_W-1:0]  rd_data;

   tdsm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_adc_sample (req_adc_sample),
      .stat           (stat),
      .tok_valid      (tok_valid),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   tdsm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tok_valid     (tok_valid),
      .stat          (stat),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tds_ppm   (rsp_tds_ppm),
      .rsp_saturated (rsp_saturated)
   );

endmodule

FILE: test/tb_tds_median_compensated_meter.sv
// Self-checking testbench for tds_median_compensated_meter.
// Depends on tdsm_pkg and the block's RTL; needs no files and no arguments.
// A queue of sample/query beats is driven under several temperature and
// reference settings, and each TDS reading is checked against a local predictor.
module tb_tds_median_compensated_meter;

   typedef struct {
      logic                       cmd;
      logic [tdsm_pkg::ADC_W-1:0] adc;
   } meter_beat_type;

   typedef struct {
      logic [tdsm_pkg::PPM_W-1:0] ppm;
      logic                       sat;
   } tds_reading_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_cmd = tdsm_pkg::CMD_SAMPLE;
   logic [tdsm_pkg::ADC_W-1:0]     req_adc_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [tdsm_pkg::PPM_W-1:0]     rsp_tds_ppm;
   logic                           rsp_saturated;
   logic                           csr_wr_en = 1'b0;
   logic [tdsm_pkg::CSR_IDX_W-1:0] csr_index = tdsm_pkg::CSR_WATER_TEMP;
   logic [tdsm_pkg::CSR_W-1:0]     csr_wr_data = '0;

   tds_median_compensated_meter u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [tdsm_pkg::ADC_W-1:0]  ring_copy [tdsm_pkg::SAMPLE_COUNT];
   int                          ring_pos;
   logic [tdsm_pkg::TEMP_W-1:0] temp_sixteenths = tdsm_pkg::TEMP_RESET;
   logic [tdsm_pkg::MV_W-1:0]   ref_mv = tdsm_pkg::MV_RESET;

   meter_beat_type  beats_to_send [$];
   tds_reading_type readings_due [$];
   int              fail_count;
   int              queries_sent;
   int              readings_checked;
   int              sat_seen;
   bit              calm;

   // median of the ring, scaled, compensated and mapped to ppm
   function automatic tds_reading_type predict_reading();
      logic [tdsm_pkg::ADC_W-1:0] s [tdsm_pkg::SAMPLE_COUNT];
      logic [tdsm_pkg::ADC_W-1:0] tmp;
      logic [63:0]                med, x, y, q, q16, t;
      tds_reading_type            r;
      for (int i = 0; i < tdsm_pkg::SAMPLE_COUNT; i++) s[i] = ring_copy[i];
      for (int i = 0; i < tdsm_pkg::SAMPLE_COUNT - 1; i++)
         for (int j = 0; j < tdsm_pkg::SAMPLE_COUNT - 1 - i; j++)
            if (s[j] > s[j+1]) begin
               tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
            end
      if (tdsm_pkg::SAMPLE_COUNT % 2 != 0)
         med = 64'(s[(tdsm_pkg::SAMPLE_COUNT-1)/2]);
      else
         med = (64'(s[tdsm_pkg::SAMPLE_COUNT/2]) + 64'(s[tdsm_pkg::SAMPLE_COUNT/2-1]))
               / 64'd2;
      x = (med * 64'(ref_mv) * 64'd64) / 64'd1000;
      y = (x * 64'd800) / (64'd400 + 64'(temp_sixteenths));
      q = 64'd13342 * y * y + (64'd85739 << 32);
      q = q - ((64'd25586 * y) << 16);
      q16 = q >> 16;
      t = (q16 * y * 64'd8) / (64'd100 << 32);
      if (t > 64'(tdsm_pkg::PPM_MAX)) begin
         r.ppm = tdsm_pkg::PPM_MAX; r.sat = 1'b1;
      end else begin
         r.ppm = tdsm_pkg::PPM_W'(t); r.sat = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // driver: one beat at a time from the queue, with random idle bursts
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_cmd == tdsm_pkg::CMD_SAMPLE) begin
               ring_copy[ring_pos] = req_adc_sample;
               ring_pos = (ring_pos + 1) % tdsm_pkg::SAMPLE_COUNT;
            end else begin
               readings_due.push_back(predict_reading());
               queries_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 5);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
               meter_beat_type b;
               b = beats_to_send.pop_front();
               req_valid      <= 1'b1;
               req_cmd        <= b.cmd;
               req_adc_sample <= b.adc;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each reading beat, stall the receiver in bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("unexpected reading", rsp_tds_ppm, -1);
            end else begin
               tds_reading_type w;
               w = readings_due.pop_front();
               if (rsp_tds_ppm !== w.ppm) report_mismatch("tds_ppm", rsp_tds_ppm, w.ppm);
               if (rsp_saturated !== w.sat)
                  report_mismatch("saturated", rsp_saturated, w.sat);
               if (w.sat) sat_seen++;
               readings_checked++;
            end
         end
         if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [tdsm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tdsm_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == tdsm_pkg::CSR_WATER_TEMP) temp_sixteenths = tdsm_pkg::TEMP_W'(val);
      else ref_mv = tdsm_pkg::MV_W'(val);
   endtask

   // sender holds off until the block is empty and every reading is back
   task automatic drain();
      do @(posedge clock);
      while (beats_to_send.size() > 0 || req_valid || readings_due.size() > 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic push_beat(input logic cmd, input logic [tdsm_pkg::ADC_W-1:0] adc);
      meter_beat_type b;
      b.cmd = cmd;
      b.adc = adc;
      beats_to_send.push_back(b);
   endtask

   // random beats: mostly sample runs with the odd query
   task automatic push_random(input int count);
      int centre;
      centre = $urandom_range(0, 1023);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 6) == 0)
            push_beat(tdsm_pkg::CMD_QUERY, tdsm_pkg::ADC_W'($urandom));
         else if ($urandom_range(0, 2) == 0)
            push_beat(tdsm_pkg::CMD_SAMPLE, tdsm_pkg::ADC_W'($urandom));
         else push_beat(tdsm_pkg::CMD_SAMPLE,
                        tdsm_pkg::ADC_W'((centre + $urandom_range(0, 64)) % 1024));
      end
   endtask

   int temps [6] = '{0, 800, 1023, 0, 200, 400};
   int mvs   [6] = '{8191, 1000, 5000, 0, 4096, 3300};

   initial begin
      for (int i = 0; i < tdsm_pkg::SAMPLE_COUNT; i++) ring_copy[i] = '0;
      ring_pos = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: query over reset zeros, extremes, then a ring majority at full scale
      write_reg(tdsm_pkg::CSR_WATER_TEMP, tdsm_pkg::CSR_W'(400));
      write_reg(tdsm_pkg::CSR_REF_MV, tdsm_pkg::CSR_W'(3300));
      push_beat(tdsm_pkg::CMD_QUERY, '0);
      push_beat(tdsm_pkg::CMD_SAMPLE, '1);
      push_beat(tdsm_pkg::CMD_SAMPLE, '0);
      push_beat(tdsm_pkg::CMD_QUERY, '1);
      for (int i = 0; i < 16; i++) push_beat(tdsm_pkg::CMD_SAMPLE, '1);
      push_beat(tdsm_pkg::CMD_QUERY, '0);
      drain();
      // large reading at high reference and cold water: clipped
      write_reg(tdsm_pkg::CSR_WATER_TEMP, tdsm_pkg::CSR_W'(0));
      write_reg(tdsm_pkg::CSR_REF_MV, tdsm_pkg::CSR_W'(8191));
      push_beat(tdsm_pkg::CMD_QUERY, '0);
      drain();

      // random phases, one per register setting; the last without idling
      foreach (temps[p]) begin
         write_reg(tdsm_pkg::CSR_WATER_TEMP, tdsm_pkg::CSR_W'(temps[p]));
         write_reg(tdsm_pkg::CSR_REF_MV, tdsm_pkg::CSR_W'(mvs[p]));
         if (p == 5) calm = 1'b1;
         push_random(100);
         push_beat(tdsm_pkg::CMD_QUERY, '0);
         drain();
      end

      repeat (1100) @(posedge clock);
      $display("covered %0d queries, %0d readings checked, %0d clipped, six settings",
               queries_sent, readings_checked, sat_seen);
      if (fail_count == 0 && readings_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (readings_due.size() != 0)
            $display("%0d readings never arrived", readings_due.size());
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 4000000);
      $display("timeout");
      $display("FAILURE");
      $finish;
   end

endmodule
